### rtl/core/upu_pkg.sv
`default_nettype none

package upu_pkg;

	localparam logic [7:0] CHAR_PERCENT = 8'h25;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;

	localparam int MAX_RESULTS = 3;

	localparam logic [1:0] PHASE_IDLE  = 2'd0;
	localparam logic [1:0] PHASE_PCT   = 2'd1;
	localparam logic [1:0] PHASE_DIGIT = 2'd2;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       ovf;
	} result_t;

	typedef struct packed {
		result_t [MAX_RESULTS-1:0] res;
		logic [1:0]                num;
	} bundle_t;

	function automatic logic is_hex(input logic [7:0] c);
		is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c <= 8'h46) begin
			v = c - 8'h37;
		end else begin
			v = c - 8'h57;
		end
		hex_val = v[3:0];
	endfunction

endpackage

`default_nettype wire

### rtl/core/upu_decode.sv
`default_nettype none

module upu_decode (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic [7:0]      c,
	input  wire logic            last,
	input  wire logic [15:0]     cap,
	output upu_pkg::bundle_t     bundle
);
	import upu_pkg::*;

	logic [1:0]  phase_q;
	logic [7:0]  held_q;
	logic [15:0] count_q;
	logic        ovf_q;

	logic [7:0]  pend [MAX_RESULTS];
	logic [1:0]  np;
	logic [1:0]  nr;
	logic [1:0]  emitted;
	logic [1:0]  nxt_phase;
	logic [7:0]  nxt_held;
	logic        do_normal;
	logic        ovf_now;
	result_t [MAX_RESULTS-1:0] res;

	// settle pending escape, then decode the current byte
	always_comb begin
		np        = 2'd0;
		pend      = '{default: 8'h00};
		nxt_phase = PHASE_IDLE;
		nxt_held  = held_q;
		do_normal = 1'b1;
		priority if (ovf_q) begin
			do_normal = 1'b0;
		end else if (phase_q == PHASE_PCT) begin
			if (is_hex(c) && !last) begin
				nxt_held  = c;
				nxt_phase = PHASE_DIGIT;
				do_normal = 1'b0;
			end else begin
				pend[0] = CHAR_PERCENT;
				np      = 2'd1;
			end
		end else if (phase_q == PHASE_DIGIT) begin
			if (is_hex(c) && is_hex(held_q)) begin
				pend[0]   = {hex_val(held_q), hex_val(c)};
				np        = 2'd1;
				do_normal = 1'b0;
			end else begin
				pend[0] = CHAR_PERCENT;
				pend[1] = held_q;
				np      = 2'd2;
			end
		end else begin
			np = 2'd0;
		end

		if (do_normal) begin
			priority if (c == CHAR_PERCENT) begin
				if (last) begin
					pend[np] = CHAR_PERCENT;
					np       = np + 2'd1;
				end else begin
					nxt_phase = PHASE_PCT;
				end
			end else if (c == CHAR_PLUS) begin
				pend[np] = CHAR_SPACE;
				np       = np + 2'd1;
			end else begin
				pend[np] = c;
				np       = np + 2'd1;
			end
		end
	end

	// capacity check per pending byte; first one over capacity closes the string
	always_comb begin
		nr      = np;
		emitted = np;
		ovf_now = 1'b0;
		for (int k = 0; k < MAX_RESULTS; k++) begin
			res[k] = '{data: pend[k], last: 1'b0, ovf: 1'b0};
		end
		for (int k = 0; k < MAX_RESULTS; k++) begin
			if (!ovf_now && 2'(k) < np &&
				({1'b0, count_q} + 17'(k)) >= {1'b0, cap}) begin
				ovf_now = 1'b1;
				nr      = 2'(k + 1);
				emitted = 2'(k);
				res[k]  = '{data: 8'h00, last: 1'b1, ovf: 1'b1};
			end
		end
		if (last && !ovf_now && nr != 2'd0) begin
			res[nr - 2'd1].last = 1'b1;
		end
	end

	assign bundle.res = res;
	assign bundle.num = nr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_IDLE;
			held_q  <= 8'h00;
			count_q <= 16'h0000;
			ovf_q   <= 1'b0;
		end else if (step) begin
			if (last) begin
				phase_q <= PHASE_IDLE;
				held_q  <= 8'h00;
				count_q <= 16'h0000;
				ovf_q   <= 1'b0;
			end else if (!ovf_q) begin
				phase_q <= nxt_phase;
				held_q  <= nxt_held;
				count_q <= count_q + 16'(emitted);
				ovf_q   <= ovf_now;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/upu_result_fifo.sv
`default_nettype none

module upu_result_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  upu_pkg::bundle_t      wr_bundle,
	output logic                  space_ok,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output upu_pkg::result_t      head
);
	import upu_pkg::*;

	localparam int DEPTH = 4;

	result_t    mem_q [DEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] level_q;
	logic [1:0] wr_num;
	logic       pop;

	assign wr_num    = wr_en ? wr_bundle.num : 2'd0;
	assign out_valid = (level_q != 3'd0);
	assign pop       = out_valid && out_ready;
	// room for a full burst of results, judged from registered level only
	assign space_ok  = (level_q <= 3'd1);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (2'(i) < wr_num) begin
				mem_q[wr_ptr_q + 2'(i)] <= wr_bundle.res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			level_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + wr_num;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			level_q <= level_q + 3'(wr_num) - 3'(pop);
		end
	end

endmodule

`default_nettype wire

### rtl/core/uri_percent_unescape.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------
// in       | in_valid / in_ready   | in_byte[7:0], in_last
// out      | out_valid / out_ready | out_byte[7:0], out_last, overflow
// cfg      | cfg_valid / cfg_ready | cfg_data[15:0] (output capacity)
//
// One encoded byte per cycle sustained while the result queue has room for a burst.
// A byte is registered, decoded against the escape and count state, and its
// zero to three results enter a four-entry result queue, drained one per cycle on out_ready.
// in_ready depends only on registered state: a new byte enters when the input
// register is empty or the queue holds at most one result, so a malformed escape
// stalls input while it drains.
// Async reset clears string state, queue and capacity (65535); cfg_ready is always high.
`default_nettype none

module uri_percent_unescape (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	input  wire logic        in_last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             out_last,
	output logic             overflow,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);
	import upu_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [15:0] cap_q;
	logic        space_ok;
	logic        take_s1;
	bundle_t     bundle;
	result_t     head;

	assign cfg_ready = 1'b1;
	assign take_s1   = valid_s1 && space_ok;
	assign in_ready  = !valid_s1 || space_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 16'hFFFF;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	upu_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (take_s1),
		.c      (byte_s1),
		.last   (last_s1),
		.cap    (cap_q),
		.bundle (bundle)
	);

	upu_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (take_s1),
		.wr_bundle (bundle),
		.space_ok  (space_ok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign out_byte = head.data;
	assign out_last = head.last;
	assign overflow = head.ovf;

endmodule

`default_nettype wire

### sim/uri_percent_unescape_tb.sv
`timescale 1ns / 100ps

module uri_percent_unescape_tb;

	import upu_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} enc_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'h00;
	logic        in_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        out_last;
	logic        overflow;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'h0000;

	// requests waiting for the driver, results waiting for the monitor
	enc_char_t enc_pending[$];
	result_t   decoded_expect[$];

	// decoder state as predicted
	logic [15:0] capacity = 16'hFFFF;
	logic [1:0]  esc_phase = PHASE_IDLE;
	logic [7:0]  held_char = 8'h00;
	logic [15:0] char_count = 16'h0000;
	bit          ovf_seen = 1'b0;

	int unsigned send_gap_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_requests = 1'b0;
	int          n_queued = 0;
	int          n_requests = 0;
	int          n_results = 0;
	int          n_overflows = 0;
	int          n_errors = 0;
	logic [15:0] last_capacity;

	uri_percent_unescape i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.overflow  (overflow),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		return -1;
	endfunction

	function automatic logic [7:0] pick_hex_char();
		string digits;
		digits = "0123456789ABCDEFabcdef";
		return digits[$urandom_range(21)];
	endfunction

	task automatic clear_string();
		esc_phase = PHASE_IDLE;
		held_char = 8'h00;
		char_count = 16'h0000;
		ovf_seen = 1'b0;
	endtask

	// Predicts the results of one accepted request and queues them.
	task automatic decode_request(input logic [7:0] c, input logic last);
		logic [7:0] pend[$];
		int         lo;
		int         hi;
		int         k;
		bit         fused;
		bit         ovf_now;
		result_t    r;
		fused = 1'b0;
		ovf_now = 1'b0;
		if (ovf_seen) begin
			if (last)
				clear_string();
			return;
		end
		case (esc_phase)
			PHASE_PCT: begin
				if (hex_digit(c) >= 0 && !last) begin
					held_char = c;
					esc_phase = PHASE_DIGIT;
					return;
				end
				pend.push_back(CHAR_PERCENT);
				esc_phase = PHASE_IDLE;
			end
			PHASE_DIGIT: begin
				lo = hex_digit(c);
				hi = hex_digit(held_char);
				esc_phase = PHASE_IDLE;
				if (lo >= 0 && hi >= 0) begin
					pend.push_back({hi[3:0], lo[3:0]});
					fused = 1'b1;
				end else begin
					pend.push_back(CHAR_PERCENT);
					pend.push_back(held_char);
				end
			end
			default: esc_phase = PHASE_IDLE;
		endcase
		if (!fused) begin
			if (c == CHAR_PERCENT) begin
				if (last)
					pend.push_back(CHAR_PERCENT);
				else
					esc_phase = PHASE_PCT;
			end else if (c == CHAR_PLUS) begin
				pend.push_back(CHAR_SPACE);
			end else begin
				pend.push_back(c);
			end
		end
		for (k = 0; k < pend.size() && !ovf_now; k++) begin
			if (char_count >= capacity) begin
				r.data = 8'h00;
				r.last = 1'b1;
				r.ovf = 1'b1;
				ovf_seen = 1'b1;
				ovf_now = 1'b1;
			end else begin
				r.data = pend[k];
				r.last = last && (k == pend.size() - 1);
				r.ovf = 1'b0;
				char_count = char_count + 16'd1;
			end
			decoded_expect.push_back(r);
		end
		if (last)
			clear_string();
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin : drv
		enc_char_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
			in_last <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				decode_request(in_byte, in_last);
				n_requests++;
			end
			if (!in_valid || in_ready) begin
				if (enc_pending.size() > 0 && !hold_requests &&
						$urandom_range(99) >= send_gap_pct) begin
					nxt = enc_pending.pop_front();
					in_valid <= 1'b1;
					in_byte <= nxt.data;
					in_last <= nxt.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin : mon
		result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				n_results++;
				if (overflow)
					n_overflows++;
				if (decoded_expect.size() == 0) begin
					$display("%0t: unexpected result byte %02h last %0b overflow %0b",
						$time, out_byte, out_last, overflow);
					n_errors++;
				end else begin
					want = decoded_expect.pop_front();
					if (out_byte !== want.data) begin
						$display("%0t: out_byte expected %02h got %02h",
							$time, want.data, out_byte);
						n_errors++;
					end
					if (out_last !== want.last) begin
						$display("%0t: out_last expected %0b got %0b",
							$time, want.last, out_last);
						n_errors++;
					end
					if (overflow !== want.ovf) begin
						$display("%0t: overflow expected %0b got %0b",
							$time, want.ovf, overflow);
						n_errors++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic queue_char(input logic [7:0] c, input logic last);
		enc_char_t e;
		e.data = c;
		e.last = last;
		enc_pending.push_back(e);
		n_queued++;
	endtask

	task automatic queue_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			queue_char(s[i], i == s.len() - 1);
	endtask

	// Mostly well-formed escapes and plain text, some broken escapes;
	// cutting at a random length also leaves escapes open at end of string.
	task automatic queue_random_string(input int max_len);
		logic [7:0] chars[$];
		int         len;
		int         pick;
		int         k;
		len = $urandom_range(max_len, 1);
		while (chars.size() < len) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				chars.push_back(8'($urandom_range(255)));
			end else if (pick < 50) begin
				chars.push_back(CHAR_PLUS);
			end else if (pick < 80) begin
				chars.push_back(CHAR_PERCENT);
				chars.push_back(pick_hex_char());
				chars.push_back(pick_hex_char());
			end else if (pick < 88) begin
				chars.push_back(CHAR_PERCENT);
				chars.push_back(8'($urandom_range(255)));
			end else if (pick < 95) begin
				chars.push_back(CHAR_PERCENT);
				chars.push_back(pick_hex_char());
				chars.push_back(8'($urandom_range(255)));
			end else begin
				chars.push_back(CHAR_PERCENT);
			end
		end
		for (k = 0; k < len; k++)
			queue_char(chars[k], k == len - 1);
	endtask

	task automatic queue_random(input int count, input int max_len);
		int target;
		target = n_queued + count;
		while (n_queued < target)
			queue_random_string(max_len);
	endtask

	// Waits until every request is taken and every result is back, then lets
	// the bench sit idle so the pipeline settles.
	task automatic drain();
		@(negedge clk);
		while (enc_pending.size() != 0 || in_valid || decoded_expect.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		capacity = value;
	endtask

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("uri_percent_unescape_tb failed");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		send_gap_pct = 8;
		recv_stall_pct = 55;

		// escapes in both cases, plus, byte extremes, broken and cut escapes
		queue_text("%4a+");
		queue_char(8'h00, 1'b0);
		queue_char(8'hFF, 1'b1);
		queue_text("%G%4z%");
		queue_text("%4");
		queue_text("%F1");
		drain();

		// one byte per string: overflow, drop after overflow, overflow mid-request
		write_capacity(16'd1);
		queue_text("ab");
		queue_text("abc");
		queue_text("%4z");
		queue_random(100, 4);
		drain();

		send_gap_pct = 55;
		recv_stall_pct = 8;
		write_capacity(16'd5);
		queue_random(150, 12);
		@(negedge clk);
		while (enc_pending.size() > 75)
			@(negedge clk);
		hold_requests = 1'b1;
		while (in_valid || decoded_expect.size() != 0)
			@(negedge clk);
		hold_requests = 1'b0;
		drain();

		write_capacity(16'hFFFF);
		queue_random(100, 24);
		drain();

		send_gap_pct = 0;
		recv_stall_pct = 0;
		write_capacity(16'd0);
		queue_random(20, 6);
		drain();

		last_capacity = 16'($urandom_range(20, 2));
		write_capacity(last_capacity);
		queue_random(100, 16);
		drain();

		$display("covered %0d requests, %0d results, %0d overflow closes", n_requests,
			n_results, n_overflows);
		$display("capacities 65535, 1, 5, 0 and %0d under three idle profiles", last_capacity);
		if (n_errors == 0) begin
			$display("uri_percent_unescape_tb passed");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("uri_percent_unescape_tb failed");
		end
		$finish;
	end

endmodule

### uri_percent_unescape.f
rtl/core/upu_pkg.sv
rtl/core/upu_decode.sv
rtl/core/upu_result_fifo.sv
rtl/core/uri_percent_unescape.sv
sim/uri_percent_unescape_tb.sv
